/* rtl/core/owbf_pkg.sv */
// shared constants and field widths for the overwrite-oldest burst fifo
package owbf_pkg;

   localparam int SLOTS_DEF        = 8;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int FUNC_W    = 1;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = 10;
   localparam int TIME_W    = 32;
   localparam int SEQ_W     = 32;
   localparam int FILL_W    = 4;
   localparam int DROP_W    = 32;

   localparam logic [FUNC_W-1:0] OP_WRITE   = 1'b0;
   localparam logic [FUNC_W-1:0] OP_CONSUME = 1'b1;

endpackage

/* rtl/core/owbf_rec_ram.sv */
// record store: one write port, one read port with registered read data
module owbf_rec_ram import owbf_pkg::*; #(
   parameter int DEPTH = SLOTS_DEF,
   parameter int WIDTH = SEQ_W + TIME_W + COUNT_W + PAYLOAD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/overwrite_oldest_burst_fifo.sv */
// top level of the overwrite-oldest burst fifo: pointers, counters and response register
// an accepted request moves to the lookup state while the record memory read completes; the
// response register is then loaded, which waits while the previous response still waits there
// the next request is accepted only once the lookup has loaded the response register
// a new request is taken while the previous response still waits in the output register
// reset (synchronous, active high) clears pointers, sequence and drop counters and handshakes
// the record memory is not cleared; only entries that were written are ever shown
module overwrite_oldest_burst_fifo import owbf_pkg::*; #(
   parameter int SLOTS        = SLOTS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [PAYLOAD_W-1:0] req_sample_payload,
   input  logic [COUNT_W-1:0]   req_sample_count,
   input  logic [TIME_W-1:0]    req_time_stamp,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_evicted,
   output logic [SEQ_W-1:0]     rsp_assigned_seq,
   output logic [FILL_W-1:0]    rsp_fill_level,
   output logic                 rsp_is_empty,
   output logic                 rsp_oldest_valid,
   output logic [SEQ_W-1:0]     rsp_oldest_seq,
   output logic [TIME_W-1:0]    rsp_oldest_time,
   output logic [COUNT_W-1:0]   rsp_oldest_count,
   output logic [PAYLOAD_W-1:0] rsp_oldest_payload,
   output logic [DROP_W-1:0]    rsp_drop_total
);

   // only the low payload bits that fit both the port and the parameter are kept
   localparam int STORE_W = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
   localparam int REC_W   = SEQ_W + TIME_W + COUNT_W + STORE_W;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   // slot index plus a lap bit: together they count modulo 2*SLOTS
   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(SLOTS - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             wr_lap_ff, wr_lap_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_lap_ff, rd_lap_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [DROP_W-1:0] drop_ff, drop_in;

   // per-request values held until the lookup finishes
   logic             evict_ff, evict_in;
   logic [SEQ_W-1:0] assigned_ff, assigned_in;
   logic             bypass_ff;
   logic [REC_W-1:0] bypass_rec_ff;

   logic             req_fire;
   logic             is_write;
   logic             was_full;
   logic             was_empty;
   logic             mem_wr_en;
   logic [REC_W-1:0] wr_rec;
   logic [REC_W-1:0] rd_rec;
   logic [REC_W-1:0] head_rec;
   logic             rsp_load;

   logic [CNT_W-1:0]   fill_now;
   logic [CNT_W+3:0]   fill_ext;
   logic               empty_now;
   logic [STORE_W-1:0] head_payload;
   logic [STORE_W+PAYLOAD_W-1:0] head_payload_ext;

   logic                 rsp_valid_ff;
   logic                 rsp_evicted_ff;
   logic [SEQ_W-1:0]     rsp_assigned_seq_ff;
   logic [FILL_W-1:0]    rsp_fill_level_ff;
   logic                 rsp_is_empty_ff;
   logic                 rsp_oldest_valid_ff;
   logic [SEQ_W-1:0]     rsp_oldest_seq_ff;
   logic [TIME_W-1:0]    rsp_oldest_time_ff;
   logic [COUNT_W-1:0]   rsp_oldest_count_ff;
   logic [PAYLOAD_W-1:0] rsp_oldest_payload_ff;
   logic [DROP_W-1:0]    rsp_drop_total_ff;

   // one request in flight at a time; the response register decouples the output side
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_write  = (req_func == OP_WRITE);

   // full when the indices meet on different laps, empty when they meet on the same lap
   assign was_full  = (wr_idx_ff == rd_idx_ff) && (wr_lap_ff != rd_lap_ff);
   assign was_empty = (wr_idx_ff == rd_idx_ff) && (wr_lap_ff == rd_lap_ff);

   assign wr_rec = {seq_ff, req_time_stamp, req_sample_count,
                    req_sample_payload[STORE_W-1:0]};
   assign mem_wr_en = req_fire && is_write;

   // pointer and counter updates happen at accept time
   always_comb begin
      wr_idx_in   = wr_idx_ff;
      wr_lap_in   = wr_lap_ff;
      rd_idx_in   = rd_idx_ff;
      rd_lap_in   = rd_lap_ff;
      seq_in      = seq_ff;
      drop_in     = drop_ff;
      evict_in    = evict_ff;
      assigned_in = assigned_ff;
      if (req_fire) begin
         evict_in    = 1'b0;
         assigned_in = '0;
         if (is_write) begin
            // overwrite oldest: a full queue drops its head first
            if (was_full) begin
               rd_idx_in = idx_next(rd_idx_ff);
               rd_lap_in = (rd_idx_ff == IDX_W'(SLOTS - 1)) ? ~rd_lap_ff : rd_lap_ff;
               drop_in   = drop_ff + 1'b1;
               evict_in  = 1'b1;
            end
            wr_idx_in   = idx_next(wr_idx_ff);
            wr_lap_in   = (wr_idx_ff == IDX_W'(SLOTS - 1)) ? ~wr_lap_ff : wr_lap_ff;
            seq_in      = seq_ff + 1'b1;
            assigned_in = seq_ff;
         end else if (!was_empty) begin
            // consume on an empty queue is ignored
            rd_idx_in = idx_next(rd_idx_ff);
            rd_lap_in = (rd_idx_ff == IDX_W'(SLOTS - 1)) ? ~rd_lap_ff : rd_lap_ff;
         end
      end
   end

   // the head read goes out at accept time at the updated read index
   owbf_rec_ram #(
      .DEPTH (SLOTS),
      .WIDTH (REC_W)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (wr_rec),
      .rd_en   (req_fire),
      .rd_addr (rd_idx_in),
      .rd_data (rd_rec)
   );

   // a write into an empty queue makes the new record the head in the same cycle,
   // so the memory read would return stale data: forward the written record instead
   always_ff @(posedge clock) begin
      if (req_fire) begin
         bypass_rec_ff <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (req_fire) begin
         bypass_ff <= is_write && was_empty;
      end
   end

   assign head_rec = bypass_ff ? bypass_rec_ff : rd_rec;

   // fill level from the already updated pointers
   always_comb begin
      if (wr_lap_ff == rd_lap_ff) begin
         fill_now = CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff);
      end else begin
         fill_now = CNT_W'(SLOTS) - CNT_W'(rd_idx_ff) + CNT_W'(wr_idx_ff);
      end
   end

   assign empty_now        = was_empty;
   assign fill_ext         = {4'b0, fill_now};
   assign head_payload     = head_rec[STORE_W-1:0];
   assign head_payload_ext = {{PAYLOAD_W{1'b0}}, head_payload};

   // the lookup completes once the response register is free or being drained
   assign rsp_load = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         wr_lap_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         rd_lap_ff    <= 1'b0;
         seq_ff       <= '0;
         drop_ff      <= '0;
         evict_ff     <= 1'b0;
         assigned_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wr_idx_ff   <= wr_idx_in;
         wr_lap_ff   <= wr_lap_in;
         rd_idx_ff   <= rd_idx_in;
         rd_lap_ff   <= rd_lap_in;
         seq_ff      <= seq_in;
         drop_ff     <= drop_in;
         evict_ff    <= evict_in;
         assigned_ff <= assigned_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register; oldest fields read as zero on an empty queue
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_evicted_ff      <= evict_ff;
         rsp_assigned_seq_ff <= assigned_ff;
         rsp_fill_level_ff   <= fill_ext[FILL_W-1:0];
         rsp_is_empty_ff     <= empty_now;
         rsp_oldest_valid_ff <= !empty_now;
         rsp_drop_total_ff   <= drop_ff;
         if (empty_now) begin
            rsp_oldest_seq_ff     <= '0;
            rsp_oldest_time_ff    <= '0;
            rsp_oldest_count_ff   <= '0;
            rsp_oldest_payload_ff <= '0;
         end else begin
            rsp_oldest_seq_ff     <= head_rec[REC_W-1 -: SEQ_W];
            rsp_oldest_time_ff    <= head_rec[REC_W-SEQ_W-1 -: TIME_W];
            rsp_oldest_count_ff   <= head_rec[STORE_W+COUNT_W-1 -: COUNT_W];
            rsp_oldest_payload_ff <= head_payload_ext[PAYLOAD_W-1:0];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_assigned_seq   = rsp_assigned_seq_ff;
   assign rsp_fill_level     = rsp_fill_level_ff;
   assign rsp_is_empty       = rsp_is_empty_ff;
   assign rsp_oldest_valid   = rsp_oldest_valid_ff;
   assign rsp_oldest_seq     = rsp_oldest_seq_ff;
   assign rsp_oldest_time    = rsp_oldest_time_ff;
   assign rsp_oldest_count   = rsp_oldest_count_ff;
   assign rsp_oldest_payload = rsp_oldest_payload_ff;
   assign rsp_drop_total     = rsp_drop_total_ff;

endmodule

/* rtl/core/owbf_checker.sv */
// port-level checks for the overwrite-oldest burst fifo, bound to the top level
module owbf_checker import owbf_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_evicted,
   input logic [SEQ_W-1:0]     rsp_assigned_seq,
   input logic [FILL_W-1:0]    rsp_fill_level,
   input logic                 rsp_is_empty,
   input logic                 rsp_oldest_valid
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_assigned_seq))
      else $error("response changed while stalled");

   // peek is meaningful exactly when the queue is not empty
   a_peek_vs_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty != rsp_oldest_valid))
      else $error("oldest_valid disagrees with is_empty");

   // an empty queue reports zero fill
   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_fill_level == '0))
      else $error("empty queue with nonzero fill");

   // an eviction leaves a full, hence non-empty, queue
   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_oldest_valid)
      else $error("eviction reported on empty queue");

endmodule

bind overwrite_oldest_burst_fifo owbf_checker u_owbf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_evicted      (rsp_evicted),
   .rsp_assigned_seq (rsp_assigned_seq),
   .rsp_fill_level   (rsp_fill_level),
   .rsp_is_empty     (rsp_is_empty),
   .rsp_oldest_valid (rsp_oldest_valid)
);

/* tb/sv/tb.sv */
// self-checking testbench for the overwrite-oldest burst fifo against a behavioral mirror
module tb;
   import owbf_pkg::*;

   localparam int SLOTS  = SLOTS_DEF;
   localparam int PTR_W  = $clog2(2 * SLOTS);
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int RANDOM_REQUESTS = 1430;

   // one request as it goes into the block
   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [PAYLOAD_W-1:0] payload;
      logic [COUNT_W-1:0]   count;
      logic [TIME_W-1:0]    stamp;
   } burst_req_type;

   // one response: status plus peek at the oldest record
   typedef struct packed {
      logic                 evicted;
      logic [SEQ_W-1:0]     assigned_seq;
      logic [FILL_W-1:0]    fill_level;
      logic                 is_empty;
      logic                 oldest_valid;
      logic [SEQ_W-1:0]     oldest_seq;
      logic [TIME_W-1:0]    oldest_time;
      logic [COUNT_W-1:0]   oldest_count;
      logic [PAYLOAD_W-1:0] oldest_payload;
      logic [DROP_W-1:0]    drop_total;
   } burst_status_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [FUNC_W-1:0]    req_func = OP_WRITE;
   logic [PAYLOAD_W-1:0] req_sample_payload = '0;
   logic [COUNT_W-1:0]   req_sample_count = '0;
   logic [TIME_W-1:0]    req_time_stamp = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_evicted;
   logic [SEQ_W-1:0]     rsp_assigned_seq;
   logic [FILL_W-1:0]    rsp_fill_level;
   logic                 rsp_is_empty;
   logic                 rsp_oldest_valid;
   logic [SEQ_W-1:0]     rsp_oldest_seq;
   logic [TIME_W-1:0]    rsp_oldest_time;
   logic [COUNT_W-1:0]   rsp_oldest_count;
   logic [PAYLOAD_W-1:0] rsp_oldest_payload;
   logic [DROP_W-1:0]    rsp_drop_total;

   overwrite_oldest_burst_fifo dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_sample_payload (req_sample_payload),
      .req_sample_count   (req_sample_count),
      .req_time_stamp     (req_time_stamp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_evicted        (rsp_evicted),
      .rsp_assigned_seq   (rsp_assigned_seq),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_oldest_valid   (rsp_oldest_valid),
      .rsp_oldest_seq     (rsp_oldest_seq),
      .rsp_oldest_time    (rsp_oldest_time),
      .rsp_oldest_count   (rsp_oldest_count),
      .rsp_oldest_payload (rsp_oldest_payload),
      .rsp_drop_total     (rsp_drop_total)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // requests waiting to be driven, responses predicted but not yet seen
   burst_req_type    burst_requests [$];
   burst_status_type status_due [$];

   // mirror of the record store and its pointers
   logic [SEQ_W-1:0]     shadow_seq     [SLOTS];
   logic [TIME_W-1:0]    shadow_time    [SLOTS];
   logic [COUNT_W-1:0]   shadow_count   [SLOTS];
   logic [PAYLOAD_W-1:0] shadow_payload [SLOTS];
   logic [PTR_W-1:0]     shadow_wr = '0;
   logic [PTR_W-1:0]     shadow_rd = '0;
   logic [SEQ_W-1:0]     shadow_next_seq = '0;
   logic [DROP_W-1:0]    shadow_drops = '0;

   int error_count = 0;
   int writes_seen = 0;
   int consumes_seen = 0;
   int empty_consumes = 0;
   int evictions_seen = 0;
   int full_hits = 0;
   int responses_checked = 0;

   // apply one accepted request to the mirror and return the response it must produce
   function automatic burst_status_type step_burst_queue(burst_req_type r);
      burst_status_type s;
      logic [PTR_W-1:0] held;
      logic [IDX_W-1:0] idx;
      s = '0;
      held = shadow_wr - shadow_rd;
      if (r.func == OP_WRITE) begin
         // full queue: drop the oldest record before storing the new one
         if (held == SLOTS) begin
            shadow_rd = shadow_rd + 1'b1;
            shadow_drops = shadow_drops + 1'b1;
            s.evicted = 1'b1;
            evictions_seen++;
         end
         idx = shadow_wr[IDX_W-1:0];
         shadow_seq[idx] = shadow_next_seq;
         shadow_time[idx] = r.stamp;
         shadow_count[idx] = r.count;
         shadow_payload[idx] = r.payload;
         s.assigned_seq = shadow_next_seq;
         shadow_next_seq = shadow_next_seq + 1'b1;
         shadow_wr = shadow_wr + 1'b1;
         writes_seen++;
      end else if (held != 0) begin
         shadow_rd = shadow_rd + 1'b1;
         consumes_seen++;
      end else begin
         // consume on an empty queue leaves everything alone
         empty_consumes++;
      end
      held = shadow_wr - shadow_rd;
      if (held == SLOTS) full_hits++;
      s.fill_level = held;
      s.is_empty = (held == 0);
      if (held != 0) begin
         idx = shadow_rd[IDX_W-1:0];
         s.oldest_valid = 1'b1;
         s.oldest_seq = shadow_seq[idx];
         s.oldest_time = shadow_time[idx];
         s.oldest_count = shadow_count[idx];
         s.oldest_payload = shadow_payload[idx];
      end
      s.drop_total = shadow_drops;
      return s;
   endfunction

   // idle length for either side: mostly none or short, a few long, with quiet runs of no idling
   function automatic int pick_idle(inout int quiet_left);
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic add_request(logic [FUNC_W-1:0] func, logic [PAYLOAD_W-1:0] payload,
                              logic [COUNT_W-1:0] count, logic [TIME_W-1:0] stamp);
      burst_req_type r;
      r.func = func;
      r.payload = payload;
      r.count = count;
      r.stamp = stamp;
      burst_requests.push_back(r);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // request driver: holds valid and payload until accepted, then idles a random while
   int req_gap = 0;
   int req_quiet = 0;
   burst_req_type req_now = '0;
   burst_req_type req_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // handshake completed at this edge: predict its response
         if (req_valid && req_ready) begin
            status_due.push_back(step_burst_queue(req_now));
         end
         // only move on when nothing is waiting for acceptance
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (burst_requests.size() > 0) begin
               req_next = burst_requests.pop_front();
               req_now = req_next;
               req_func <= req_next.func;
               req_sample_payload <= req_next.payload;
               req_sample_count <= req_next.count;
               req_time_stamp <= req_next.stamp;
               req_valid <= 1'b1;
               req_gap = pick_idle(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks every accepted response, stalls ready at random
   int rsp_stall = 0;
   int rsp_quiet = 0;
   burst_status_type seen;
   burst_status_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_evicted, rsp_assigned_seq, rsp_fill_level, rsp_is_empty,
                    rsp_oldest_valid, rsp_oldest_seq, rsp_oldest_time, rsp_oldest_count,
                    rsp_oldest_payload, rsp_drop_total};
            if (status_due.size() == 0) begin
               error_count++;
               $display("%0t: response with nothing expected, actual 0x%0h", $time, seen);
            end else begin
               want = status_due.pop_front();
               responses_checked++;
               check_field("evicted", 64'(want.evicted), 64'(seen.evicted));
               check_field("assigned_seq", 64'(want.assigned_seq), 64'(seen.assigned_seq));
               check_field("fill_level", 64'(want.fill_level), 64'(seen.fill_level));
               check_field("is_empty", 64'(want.is_empty), 64'(seen.is_empty));
               check_field("oldest_valid", 64'(want.oldest_valid), 64'(seen.oldest_valid));
               check_field("oldest_seq", 64'(want.oldest_seq), 64'(seen.oldest_seq));
               check_field("oldest_time", 64'(want.oldest_time), 64'(seen.oldest_time));
               check_field("oldest_count", 64'(want.oldest_count), 64'(seen.oldest_count));
               check_field("oldest_payload", 64'(want.oldest_payload),
                           64'(seen.oldest_payload));
               check_field("drop_total", 64'(want.drop_total), 64'(seen.drop_total));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_idle(rsp_quiet);
         end
      end
   end

   // stimulus and end of run
   int left;
   int chunk;
   int write_pct;
   int k;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: consume on empty right after reset
      add_request(OP_CONSUME, '1, '1, '1);
      // fill to the brim with the field extremes
      add_request(OP_WRITE, '0, '0, '0);
      add_request(OP_WRITE, '1, '1, '1);
      add_request(OP_WRITE, 32'hA5A5_5A5A, 10'h2AA, 32'h5555_AAAA);
      add_request(OP_WRITE, 32'h5A5A_A5A5, 10'h155, 32'hAAAA_5555);
      add_request(OP_WRITE, 32'h8000_0001, 10'h200, 32'h8000_0000);
      add_request(OP_WRITE, 32'h0000_0001, 10'h001, 32'h0000_0001);
      add_request(OP_WRITE, 32'h7FFF_FFFF, 10'h1FF, 32'h7FFF_FFFF);
      add_request(OP_WRITE, 32'hFFFF_FFFE, 10'h3FE, 32'hFFFF_FFFE);
      // write while full evicts the oldest
      add_request(OP_WRITE, 32'h1234_5678, 10'h3FF, 32'hDEAD_BEEF);
      add_request(OP_WRITE, 32'hCAFE_F00D, 10'h000, 32'h0000_0000);
      // drain to empty, then consume on empty again
      for (k = 0; k < SLOTS; k++) begin
         add_request(OP_CONSUME, $urandom, COUNT_W'($urandom), $urandom);
      end
      add_request(OP_CONSUME, '0, '0, '0);
      add_request(OP_WRITE, '1, '1, '0);
      add_request(OP_CONSUME, '0, '0, '0);

      // random: phases of varying write bias, so the queue swings between empty and full
      left = RANDOM_REQUESTS;
      while (left > 0) begin
         chunk = $urandom_range(20, 80);
         if (chunk > left) chunk = left;
         case ($urandom_range(0, 3))
            0: write_pct = 20;
            1: write_pct = 50;
            2: write_pct = 80;
            default: write_pct = 95;
         endcase
         for (k = 0; k < chunk; k++) begin
            add_request(($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_CONSUME,
                        pick_word(),
                        ($urandom_range(0, 9) == 0) ? '1 : COUNT_W'($urandom_range(0, 1023)),
                        pick_word());
         end
         left -= chunk;
      end

      // let everything drain, then idle on for anything stray
      while (burst_requests.size() > 0 || req_valid) @(negedge clock);
      while (status_due.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d writes, %0d consumes, %0d consumes on empty, %0d evictions",
               writes_seen, consumes_seen, empty_consumes, evictions_seen);
      $display("queue reached full %0d times, %0d responses checked, %0d errors",
               full_hits, responses_checked, error_count);
      if (error_count == 0) begin
         $display("overwrite_oldest_burst_fifo regression: pass");
      end else begin
         $display("overwrite_oldest_burst_fifo regression: fail");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #15000000;
      $display("timeout with %0d responses outstanding", status_due.size());
      $display("overwrite_oldest_burst_fifo regression: fail");
      $finish;
   end

endmodule
